// ----- rtl/core/trcp_pkg.sv -----
`default_nettype none

package trcp_pkg;

    // Field and state widths
    localparam int LEN_W   = 7;
    localparam int CHAR_W  = 8;
    localparam int VAL_W   = 16;
    localparam int IDX_W   = 6;
    localparam int IDLE_W  = 16;
    localparam int CNT_W   = 7;
    localparam int STAT_W  = 3;

    // Config port
    localparam int CFG_AW  = 4;
    localparam int CFG_DW  = 32;

    // Register word indexes (paddr[3:2])
    localparam logic [1:0] CFG_FIRST_LETTER   = 2'd0;
    localparam logic [1:0] CFG_REGISTER_COUNT = 2'd1;
    localparam logic [1:0] CFG_IDLE_LIMIT     = 2'd2;

    // Register reset values
    localparam logic [CHAR_W-1:0] RST_FIRST_LETTER   = 8'd65;
    localparam logic [CNT_W-1:0]  RST_REGISTER_COUNT = 7'd8;
    localparam logic [IDLE_W-1:0] RST_IDLE_LIMIT     = 16'd10;

    // Result status codes
    localparam logic [STAT_W-1:0] STATUS_NONE     = 3'd0;
    localparam logic [STAT_W-1:0] STATUS_ACCEPTED = 3'd1;
    localparam logic [STAT_W-1:0] STATUS_WRONG    = 3'd2;
    localparam logic [STAT_W-1:0] STATUS_UNKNOWN  = 3'd3;
    localparam logic [STAT_W-1:0] STATUS_TIMEOUT  = 3'd4;

    typedef struct packed {
        logic              has_char;
        logic [CHAR_W-1:0] char_code;
    } t_cmd_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              write_enable;
        logic [IDX_W-1:0]  reg_index;
        logic [VAL_W-1:0]  reg_value;
    } t_res_item;

    typedef struct packed {
        logic [CHAR_W-1:0] first_letter;
        logic [CNT_W-1:0]  register_count;
        logic [IDLE_W-1:0] idle_limit;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/core/trcp_if.sv -----
`default_nettype none

// Command character channel
interface trcp_cmd_if;
    import trcp_pkg::*;
    logic      valid;
    logic      ready;
    t_cmd_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Parse result channel
interface trcp_res_if;
    import trcp_pkg::*;
    logic      valid;
    logic      ready;
    t_res_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/trcp_apb_regs.sv -----
`default_nettype none

module trcp_apb_regs (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [trcp_pkg::CFG_AW-1:0] paddr,
    input  logic [trcp_pkg::CFG_DW-1:0] pwdata,
    output logic [trcp_pkg::CFG_DW-1:0] prdata,
    output logic                     pready,
    output trcp_pkg::t_cfg           o_cfg
);
    import trcp_pkg::*;

    logic [CHAR_W-1:0] r_first_letter;
    logic [CNT_W-1:0]  r_register_count;
    logic [IDLE_W-1:0] r_idle_limit;
    logic              wr_en;
    logic [1:0]        word_sel;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite;
    assign word_sel = paddr[3:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_letter   <= RST_FIRST_LETTER;
            r_register_count <= RST_REGISTER_COUNT;
            r_idle_limit     <= RST_IDLE_LIMIT;
        end else if (wr_en) begin
            unique case (word_sel)
                CFG_FIRST_LETTER:   r_first_letter   <= pwdata[CHAR_W-1:0];
                CFG_REGISTER_COUNT: r_register_count <= pwdata[CNT_W-1:0];
                CFG_IDLE_LIMIT:     r_idle_limit     <= pwdata[IDLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (word_sel)
            CFG_FIRST_LETTER:   prdata = {{(CFG_DW-CHAR_W){1'b0}}, r_first_letter};
            CFG_REGISTER_COUNT: prdata = {{(CFG_DW-CNT_W){1'b0}}, r_register_count};
            CFG_IDLE_LIMIT:     prdata = {{(CFG_DW-IDLE_W){1'b0}}, r_idle_limit};
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.first_letter   = r_first_letter;
    assign o_cfg.register_count = r_register_count;
    assign o_cfg.idle_limit     = r_idle_limit;

endmodule

`default_nettype wire

// ----- rtl/core/trcp_parser.sv -----
`default_nettype none

module trcp_parser #(
    parameter int LINE_LIMIT = 100
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  trcp_pkg::t_cmd_item i_item,
    input  trcp_pkg::t_cfg      i_cfg,
    output trcp_pkg::t_res_item o_res
);
    import trcp_pkg::*;

    localparam logic [LEN_W-1:0]  LIMIT     = LEN_W'(LINE_LIMIT);
    localparam logic [CNT_W-1:0]  MAX_REGS  = 7'd64;
    localparam logic [CNT_W-1:0]  DCNT_MAX  = 7'd127;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
    localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF     = 8'h46;
    localparam logic [CHAR_W-1:0] TEN       = 8'd10;
    localparam logic [LEN_W-1:0]  POS_LET   = 7'd0;
    localparam logic [LEN_W-1:0]  POS_EQ    = 7'd1;
    localparam logic [LEN_W-1:0]  POS_HEX   = 7'd3;

    // Line state
    logic [LEN_W-1:0]  r_line_length, n_line_length;
    logic [IDLE_W-1:0] r_idle_count,  n_idle_count;
    logic [CHAR_W-1:0] r_letter,      n_letter;
    logic              r_equals,      n_equals;
    logic              r_hex,         n_hex;
    logic [CNT_W-1:0]  r_digit_count, n_digit_count;
    logic [VAL_W-1:0]  r_accum,       n_accum;
    logic              r_fmt_err,     n_fmt_err;
    logic              r_ovf,         n_ovf;

    logic [CHAR_W-1:0] c;
    logic              is_dec, is_lo, is_up, is_digit;
    logic [3:0]        dval;
    logic [19:0]       acc_x10, acc_x16, next_val;
    logic [CNT_W-1:0]  cnt;
    logic [CHAR_W:0]   upper;
    logic              in_range, known, hex_start;

    assign c = i_item.char_code;

    // Digit decode for the current base
    always_comb begin
        is_dec   = (c >= CH_0) && (c <= CH_9);
        is_lo    = r_hex && (c >= CH_LA) && (c <= CH_LF);
        is_up    = r_hex && (c >= CH_UA) && (c <= CH_UF);
        is_digit = is_dec || is_lo || is_up;
        if (is_dec)      dval = 4'(c - CH_0);
        else if (is_lo)  dval = 4'(c - CH_LA + TEN);
        else             dval = 4'(c - CH_UA + TEN);
    end

    // Accumulate: value * base + digit, base 10 as two shifts
    assign acc_x10  = ({4'b0, r_accum} << 3) + ({4'b0, r_accum} << 1);
    assign acc_x16  = {r_accum, 4'b0};
    assign next_val = (r_hex ? acc_x16 : acc_x10) + {16'b0, dval};

    // Letter range check, count capped at 64
    assign cnt      = (i_cfg.register_count > MAX_REGS) ? MAX_REGS : i_cfg.register_count;
    assign upper    = {1'b0, i_cfg.first_letter} + {2'b0, cnt};
    assign in_range = (r_letter >= i_cfg.first_letter) && ({1'b0, r_letter} < upper);
    assign known    = in_range && r_equals && (r_line_length >= POS_HEX);

    assign hex_start = (r_line_length == POS_HEX) && (c == CH_X) && !r_hex && !r_fmt_err
                       && (r_digit_count == 7'd1) && (r_accum == '0);

    // Next state and result
    always_comb begin
        n_line_length = r_line_length;
        n_idle_count  = r_idle_count;
        n_letter      = r_letter;
        n_equals      = r_equals;
        n_hex         = r_hex;
        n_digit_count = r_digit_count;
        n_accum       = r_accum;
        n_fmt_err     = r_fmt_err;
        n_ovf         = r_ovf;
        o_res         = '0;
        o_res.status  = STATUS_NONE;

        if (i_item.has_char) begin
            n_idle_count = '0;
            if (r_line_length < LIMIT) begin
                n_line_length = r_line_length + 7'd1;
                if (c == CH_SEMI) begin
                    // end of command: evaluate and empty the line
                    if (!known) begin
                        o_res.status = STATUS_UNKNOWN;
                    end else if (r_fmt_err || r_ovf || (r_hex && r_digit_count == '0)) begin
                        o_res.status = STATUS_WRONG;
                    end else begin
                        o_res.status       = STATUS_ACCEPTED;
                        o_res.write_enable = 1'b1;
                        o_res.reg_index    = IDX_W'(r_letter - i_cfg.first_letter);
                        o_res.reg_value    = r_accum;
                    end
                    n_line_length = '0;
                    n_letter      = '0;
                    n_equals      = 1'b0;
                    n_hex         = 1'b0;
                    n_digit_count = '0;
                    n_accum       = '0;
                    n_fmt_err     = 1'b0;
                    n_ovf         = 1'b0;
                end else if (r_line_length == POS_LET) begin
                    n_letter = c;
                end else if (r_line_length == POS_EQ) begin
                    n_equals = (c == CH_EQ);
                end else if (hex_start) begin
                    n_hex         = 1'b1;
                    n_digit_count = '0;
                end else if (!is_digit) begin
                    n_fmt_err = 1'b1;
                end else begin
                    if (!r_ovf) begin
                        if (next_val[19:16] != 4'd0) n_ovf = 1'b1;
                        else n_accum = next_val[VAL_W-1:0];
                    end
                    if (r_digit_count < DCNT_MAX) n_digit_count = r_digit_count + 7'd1;
                end
            end
        end else begin
            // idle poll: count, then time out a partial line
            if (r_idle_count < i_cfg.idle_limit) begin
                n_idle_count = r_idle_count + 16'd1;
            end else if (r_line_length != '0) begin
                o_res.status  = STATUS_TIMEOUT;
                n_line_length = '0;
                n_letter      = '0;
                n_equals      = 1'b0;
                n_hex         = 1'b0;
                n_digit_count = '0;
                n_accum       = '0;
                n_fmt_err     = 1'b0;
                n_ovf         = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= '0;
            r_idle_count  <= '0;
            r_letter      <= '0;
            r_equals      <= 1'b0;
            r_hex         <= 1'b0;
            r_digit_count <= '0;
            r_accum       <= '0;
            r_fmt_err     <= 1'b0;
            r_ovf         <= 1'b0;
        end else if (i_step) begin
            r_line_length <= n_line_length;
            r_idle_count  <= n_idle_count;
            r_letter      <= n_letter;
            r_equals      <= n_equals;
            r_hex         <= n_hex;
            r_digit_count <= n_digit_count;
            r_accum       <= n_accum;
            r_fmt_err     <= n_fmt_err;
            r_ovf         <= n_ovf;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/terminal_register_command_parser_top.sv -----
// Channel   Dir  Word                                   Handshake
// i_cmd     in   has_char, char_code                    valid/ready
// o_res     out  status, write_enable, reg_index/value  valid/ready
// APB       in   first_letter, register_count, idle_lim psel/penable, pready tied high
//
// One word per cycle sustained while o_res is ready; each word passes the input
// register, then one parse step into the result register.
// The parse step runs whenever the input register holds a word and the
// result register is empty or being drained; o_res stalls back up into
// i_cmd.ready through that condition. Reset (synchronous, active low)
// empties both registers, clears the line state and restores register defaults.
`default_nettype none

module terminal_register_command_parser_top #(
    parameter int LINE_LIMIT = 100
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    trcp_cmd_if.sink                    i_cmd,
    trcp_res_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [trcp_pkg::CFG_AW-1:0] paddr,
    input  logic [trcp_pkg::CFG_DW-1:0] pwdata,
    output logic [trcp_pkg::CFG_DW-1:0] prdata,
    output logic                        pready
);
    import trcp_pkg::*;

    t_cfg      cfg;
    t_cmd_item r_in;
    logic      r_in_valid;
    t_res_item r_res, n_res;
    logic      r_res_valid;
    logic      step, in_take;

    trcp_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    trcp_parser #(.LINE_LIMIT(LINE_LIMIT)) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (n_res)
    );

    // Pipeline control
    assign step        = r_in_valid && (!r_res_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || step;
    assign in_take     = i_cmd.valid && i_cmd.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_cmd.data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (step) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_res;

endmodule

`default_nettype wire

// ----- rtl/core/trcp_checker.sv -----
`default_nettype none

module trcp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic        i_write_enable,
    input logic [5:0]  i_reg_index,
    input logic [15:0] i_reg_value
);
    import trcp_pkg::*;

    // A write goes out exactly with an accepted command
    a_we_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_write_enable == (i_status == STATUS_ACCEPTED)))
        else $error("write_enable disagrees with status");

    // Non-write words carry zero index and value
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_write_enable) |-> (i_reg_index == '0 && i_reg_value == '0))
        else $error("index or value set on a non-write word");

    // Status stays within its codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status <= STATUS_TIMEOUT))
        else $error("status code out of range");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status)
            && $stable(i_write_enable) && $stable(i_reg_index) && $stable(i_reg_value)))
        else $error("stalled result changed");

    // Leaving reset: pipeline empty and input open
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!i_out_valid && i_in_ready))
        else $error("pipeline not empty after reset");

endmodule

bind terminal_register_command_parser_top trcp_checker u_trcp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_cmd.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_status       (o_res.data.status),
    .i_write_enable (o_res.data.write_enable),
    .i_reg_index    (o_res.data.reg_index),
    .i_reg_value    (o_res.data.reg_value)
);

`default_nettype wire

// ----- dv/trcp_checker.sv -----
module trcp_scoreboard #(
    parameter int LINE_LIMIT = 100
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  logic                        i_cmd_ready,
    input  trcp_pkg::t_cmd_item         i_cmd_data,
    input  logic                        i_res_valid,
    input  logic                        i_res_ready,
    input  trcp_pkg::t_res_item         i_res_data,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [trcp_pkg::CFG_AW-1:0] i_paddr,
    input  logic [trcp_pkg::CFG_DW-1:0] i_pwdata,
    output int                          o_pending,
    output int                          o_fail_count
);
    import trcp_pkg::*;

    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_HEX_X  = 8'h78;
    localparam int BASE_DEC    = 10;
    localparam int BASE_HEX    = 16;
    localparam int VALUE_LIMIT = 'h10000;
    localparam int MAX_REGS    = 64;
    localparam int DIGIT_CAP   = 127;
    localparam int MIN_CMD_LEN = 4;

    // Shadow of the configuration registers
    logic [CHAR_W-1:0] first_letter_q;
    logic [CNT_W-1:0]  reg_count_q;
    logic [IDLE_W-1:0] idle_limit_q;

    // Partial line state
    int                line_len;
    logic [IDLE_W-1:0] idle_polls;
    logic [CHAR_W-1:0] cmd_letter;
    bit                eq_seen;
    bit                hex_on;
    bit                bad_digit;
    bit                too_big;
    int                digits;
    int                accum;

    t_res_item expected_results[$];

    function automatic void clear_line();
        line_len   = 0;
        cmd_letter = '0;
        eq_seen    = 1'b0;
        hex_on     = 1'b0;
        digits     = 0;
        accum      = 0;
        bad_digit  = 1'b0;
        too_big    = 1'b0;
    endfunction

    // -1 when c is no digit of the current base
    function automatic int digit_value(logic [CHAR_W-1:0] c, bit hex);
        if (c >= "0" && c <= "9") begin
            return int'(c - "0");
        end
        if (hex && c >= "a" && c <= "f") begin
            return int'(c - "a") + 10;
        end
        if (hex && c >= "A" && c <= "F") begin
            return int'(c - "A") + 10;
        end
        return -1;
    endfunction

    // One command word in, the result word it causes out
    function automatic t_res_item parse_word(t_cmd_item w);
        t_res_item r;
        int        pos;
        int        cnt;
        int        d;
        int        nxt;
        bit        known;
        r = '0;
        if (w.has_char) begin
            idle_polls = '0;
            if (line_len < LINE_LIMIT) begin
                pos = line_len;
                line_len++;
                if (w.char_code == CH_SEMI) begin
                    cnt   = (reg_count_q > MAX_REGS) ? MAX_REGS : int'(reg_count_q);
                    known = cmd_letter >= first_letter_q &&
                            int'(cmd_letter) < int'(first_letter_q) + cnt &&
                            eq_seen && line_len >= MIN_CMD_LEN;
                    if (!known) begin
                        r.status = STATUS_UNKNOWN;
                    end else if (bad_digit || too_big || (hex_on && digits == 0)) begin
                        r.status = STATUS_WRONG;
                    end else begin
                        r.status       = STATUS_ACCEPTED;
                        r.write_enable = 1'b1;
                        r.reg_index    = IDX_W'(cmd_letter - first_letter_q);
                        r.reg_value    = VAL_W'(accum);
                    end
                    clear_line();
                end else if (pos == 0) begin
                    cmd_letter = w.char_code;
                end else if (pos == 1) begin
                    eq_seen = (w.char_code == CH_EQUALS);
                end else if (pos == 3 && w.char_code == CH_HEX_X && !hex_on && !bad_digit &&
                             digits == 1 && accum == 0) begin
                    // "0x" prefix switches to hex
                    hex_on = 1'b1;
                    digits = 0;
                end else begin
                    d = digit_value(w.char_code, hex_on);
                    if (d < 0) begin
                        bad_digit = 1'b1;
                    end else begin
                        if (!too_big) begin
                            nxt = accum * (hex_on ? BASE_HEX : BASE_DEC) + d;
                            if (nxt >= VALUE_LIMIT) too_big = 1'b1;
                            else accum = nxt;
                        end
                        if (digits < DIGIT_CAP) digits++;
                    end
                end
            end
        end else if (idle_polls < idle_limit_q) begin
            idle_polls++;
        end else if (line_len != 0) begin
            clear_line();
            r.status = STATUS_TIMEOUT;
        end
        return r;
    endfunction

    function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Watch config writes, command words and result words
    always @(posedge i_clk) begin : monitor
        t_res_item exp_word;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            first_letter_q = RST_FIRST_LETTER;
            reg_count_q    = RST_REGISTER_COUNT;
            idle_limit_q   = RST_IDLE_LIMIT;
            idle_polls     = '0;
            clear_line();
            expected_results.delete();
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[CFG_AW-1:2])
                    CFG_FIRST_LETTER:   first_letter_q = i_pwdata[CHAR_W-1:0];
                    CFG_REGISTER_COUNT: reg_count_q    = i_pwdata[CNT_W-1:0];
                    CFG_IDLE_LIMIT:     idle_limit_q   = i_pwdata[IDLE_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result word with none expected, got status %0d value %0h",
                             $time, i_res_data.status, i_res_data.reg_value);
                    errs++;
                end else begin
                    exp_word = expected_results.pop_front();
                    errs += field_mismatch("status", 32'(exp_word.status),
                                           32'(i_res_data.status));
                    errs += field_mismatch("write_enable", 32'(exp_word.write_enable),
                                           32'(i_res_data.write_enable));
                    errs += field_mismatch("reg_index", 32'(exp_word.reg_index),
                                           32'(i_res_data.reg_index));
                    errs += field_mismatch("reg_value", 32'(exp_word.reg_value),
                                           32'(i_res_data.reg_value));
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                expected_results.push_back(parse_word(i_cmd_data));
            end
            o_pending    <= expected_results.size();
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

// ----- dv/tb.sv -----
module tb;
    import trcp_pkg::*;

    localparam int LINE_LIMIT    = 100;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_WORDS   = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 10;
    localparam int SHORT_IDLE    = 40;
    localparam int MAX_REGS      = 64;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    int chk_pending;
    int chk_fail;
    int words_sent;
    bit tx_idle_en;
    bit rx_idle_en;
    bit hold_off_req;

    // Current register settings, for steering the stimulus
    logic [CHAR_W-1:0] cur_first;
    logic [CNT_W-1:0]  cur_count;
    logic [IDLE_W-1:0] cur_idle;

    trcp_cmd_if cmd_ch ();
    trcp_res_if res_ch ();

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    terminal_register_command_parser_top #(
        .LINE_LIMIT(LINE_LIMIT)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    trcp_scoreboard #(
        .LINE_LIMIT(LINE_LIMIT)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_ch.valid),
        .i_cmd_ready  (cmd_ch.ready),
        .i_cmd_data   (cmd_ch.data),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_res_data   (res_ch.data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_pending    (chk_pending),
        .o_fail_count (chk_fail)
    );

    // One command word, held until accepted
    task automatic send_word(input bit has, input logic [CHAR_W-1:0] code);
        if (tx_idle_en && $urandom_range(99) < 8) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= {has, code};
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_word(1'b1, s[i]);
        end
    endtask

    task automatic send_idle_polls(input int n);
        repeat (n) send_word(1'b0, CHAR_W'($urandom_range(255)));
    endtask

    // Stop offering words and let every expected result come back
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [CFG_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // letter '=' number ';' with random content, optionally with one bad character
    task automatic send_command(input bit corrupt);
        string             num;
        int                v;
        int                cnt;
        int                letter_i;
        bit                hex;
        logic [CHAR_W-1:0] letter;
        logic [CHAR_W-1:0] bad;
        if (cur_count != 0 && $urandom_range(9) != 0) begin
            cnt      = (cur_count > MAX_REGS) ? MAX_REGS : int'(cur_count);
            letter_i = int'(cur_first) + $urandom_range(cnt - 1);
            letter   = (letter_i > 255) ? 8'hFF : CHAR_W'(letter_i);
        end else begin
            letter = CHAR_W'($urandom_range(255));
        end
        hex = $urandom_range(1);
        case ($urandom_range(9))
            0, 1, 2: v = $urandom_range(9);
            3:       v = $urandom_range(1) ? 'hFFFF : 'h10000;
            4:       v = $urandom_range('hFFFF, 'hFFFFF);
            default: v = $urandom_range('hFFFF);
        endcase
        if ($urandom_range(19) == 0) begin
            num = hex ? "0x" : "";
        end else if (hex) begin
            num = $sformatf("%0x", v);
            if ($urandom_range(1)) num = num.toupper();
            num = {"0x", num};
        end else begin
            num = $sformatf("%0d", v);
            if ($urandom_range(9) == 0) num = {"0", num};
        end
        if (corrupt && num.len() > 0) begin
            case ($urandom_range(6))
                0:       bad = " ";
                1:       bad = "+";
                2:       bad = "-";
                3:       bad = "X";
                4:       bad = "g";
                5:       bad = "x";
                default: bad = CHAR_W'($urandom_range(1, 255));
            endcase
            num[$urandom_range(num.len() - 1)] = bad;
        end
        send_word(1'b1, letter);
        send_word(1'b1, ($urandom_range(19) == 0) ? CHAR_W'($urandom_range(255)) : "=");
        for (int i = 0; i < num.len(); i++) begin
            // occasional idle poll inside the line
            if ($urandom_range(99) < 3) send_idle_polls(1);
            send_word(1'b1, num[i]);
        end
        send_word(1'b1, ";");
    endtask

    // Enough idle polls to clear a partial line when the limit is short
    task automatic send_idle_run();
        if ($urandom_range(1)) send_text("A=1");
        if (cur_idle <= SHORT_IDLE) send_idle_polls(int'(cur_idle) + $urandom_range(1, 3));
        else send_idle_polls($urandom_range(1, 5));
    endtask

    task automatic run_phase(input logic [CHAR_W-1:0] first, input logic [CNT_W-1:0] count,
                             input logic [IDLE_W-1:0] idle, input bit long_line,
                             input bit hold_off);
        int start;
        int sel;
        wait_drained();
        apb_write(CFG_FIRST_LETTER, CFG_DW'(first));
        apb_write(CFG_REGISTER_COUNT, CFG_DW'(count));
        apb_write(CFG_IDLE_LIMIT, CFG_DW'(idle));
        cur_first = first;
        cur_count = count;
        cur_idle  = idle;
        if (hold_off) hold_off_req = 1'b1;
        // Overflow the line buffer, then let the idle timeout empty it
        if (long_line) begin
            repeat (LINE_LIMIT + 4) send_word(1'b1, CHAR_W'($urandom_range(97, 122)));
            send_text(";;");
            send_idle_polls(int'(idle) + 2);
        end
        start = words_sent;
        while (words_sent - start < PHASE_WORDS) begin
            sel = $urandom_range(99);
            if (sel < 80) begin
                send_command($urandom_range(99) < 15);
            end else if (sel < 90) begin
                repeat ($urandom_range(1, 4)) begin
                    send_word($urandom_range(1), CHAR_W'($urandom_range(255)));
                end
            end else begin
                send_idle_run();
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin : receiver
        res_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                res_ch.ready <= !(rx_idle_en && $urandom_range(99) < 8);
            end
        end
    end

    initial begin : stimulus
        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_rst_n      <= 1'b0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        hold_off_req = 1'b0;
        words_sent   = 0;
        cur_first    = RST_FIRST_LETTER;
        cur_count    = RST_REGISTER_COUNT;
        cur_idle     = RST_IDLE_LIMIT;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed lines at the reset settings (A..H, idle limit 10)
        send_text("A=0;");
        send_text("H=65535;");
        send_text("A=65536;");
        send_text("B=0xffff;");
        send_text("C=0xFFFF;");
        send_text("D=0x10000;");
        send_text("E=0xaB;");
        send_text("F=0099;");
        send_text("I=5;");
        send_text("@=5;");
        send_text("A:5;");
        send_text("A=;");
        send_text(";");
        send_text("A=0x;");
        send_text("A=0x1x2;");
        send_text("A=0X5;");
        send_text("A= 5;");
        send_text("A=+5;");
        send_text("A=-5;");
        // zero byte inside the number and as the letter
        send_text("A=5");
        send_word(1'b1, 8'h00);
        send_text(";");
        send_word(1'b1, 8'h00);
        send_text("=1;");
        // idle timeout, empty line then partial line
        send_idle_polls(12);
        send_text("G=7");
        send_idle_polls(11);
        send_text(";");

        run_phase(8'd65, 7'd8, 16'd10, 1'b0, 1'b0);
        run_phase(8'd0, 7'd64, 16'd0, 1'b0, 1'b0);
        run_phase(8'd255, 7'd127, 16'd3, 1'b1, 1'b0);
        run_phase(8'd97, 7'd0, 16'd65535, 1'b0, 1'b0);
        run_phase(8'd48, 7'd26, 16'd1, 1'b0, 1'b0);
        // no idling on either side, with one long hold-off on the result side
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_phase(8'd200, 7'd64, 16'd20, 1'b0, 1'b1);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        run_phase(8'd65, 7'd1, 16'd5, 1'b1, 1'b0);
        run_phase(8'd90, 7'd65, 16'd2, 1'b0, 1'b0);

        wait_drained();
        repeat (END_CYCLES) @(negedge i_clk);
        if (chk_fail == 0) begin
            $display("[terminal_register_command_parser_top] OK");
        end else begin
            $display("[terminal_register_command_parser_top] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("[terminal_register_command_parser_top] ERROR");
        $finish;
    end

endmodule

// ----- terminal_register_command_parser_top.f -----
rtl/core/trcp_pkg.sv
rtl/core/trcp_if.sv
rtl/core/trcp_apb_regs.sv
rtl/core/trcp_parser.sv
rtl/core/terminal_register_command_parser_top.sv
rtl/core/trcp_checker.sv
dv/trcp_checker.sv
dv/tb.sv
